FILE: hw/rtl/gsfd_pkg.sv
// Package: constants and codes used by the gas sensor frame deframer top level.
`default_nettype none
package gsfd_pkg;

  localparam int unsigned NumChan  = 5;
  localparam int unsigned RamDepth = 2 * NumChan;
  localparam int unsigned RamAw    = $clog2(RamDepth);
  localparam int unsigned ChanW    = 3;

  localparam logic [4:0] PosId     = 5'd2;
  localparam logic [4:0] PosStatus = 5'd3;
  localparam logic [4:0] PosWave   = 5'd4;
  localparam logic [4:0] PosSlow   = 5'd14;
  localparam logic [4:0] PosSum    = 5'd20;

  localparam logic [1:0] RegSyncFirst  = 2'd0;
  localparam logic [1:0] RegSyncSecond = 2'd1;
  localparam logic [1:0] RegIdLimit    = 2'd2;

  typedef enum logic [1:0] {
    ErrOk  = 2'd0,
    ErrId  = 2'd1,
    ErrSum = 2'd2
  } err_e;

endpackage
`default_nettype wire

FILE: hw/rtl/gsfd_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module gsfd_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/gas_sensor_frame_deframer.sv
// Top level: byte-serial sync-pair frame parser with checksum and id checks.
//
// Takes one received byte per cycle while in_stall_o is low. After the two
// sync bytes it collects frame bytes 2 to 20; the five waveform words go into
// a two-bank word RAM, one bank per frame, so a new frame is collected while
// the previous one is reported. A good frame gives five items, a bad one a
// single error item. Each item passes a word RAM read, then the output
// register. The checksum byte of a frame is held off only while the previous
// frame's items are still being read out of the RAM. Registers: sync_first at
// 0x0, sync_second at 0x4, frame_id_limit at 0x8.
`default_nettype none
module gas_sensor_frame_deframer (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  rx_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [1:0]       fault_code_o,
  output logic [7:0]       frame_kind_o,
  output logic [7:0]       status_flags_o,
  output logic [2:0]       channel_o,
  output logic [15:0]      wave_value_o,
  output logic             wave_valid_o,
  output logic [47:0]      slow_raw_o,
  output logic [4:0]       slow_invalid_o,
  output logic             last_o
);

  localparam logic [1:0] PhHunt    = 2'd0;
  localparam logic [1:0] PhSync2   = 2'd1;
  localparam logic [1:0] PhCollect = 2'd2;

  localparam logic [gsfd_pkg::ChanW-1:0] LastChan = gsfd_pkg::ChanW'(gsfd_pkg::NumChan - 1);
  localparam logic [gsfd_pkg::RamAw-1:0] BankOff  = gsfd_pkg::RamAw'(gsfd_pkg::NumChan);

  // configuration
  logic [7:0] sync_first_q, sync_second_q, id_limit_q;
  logic       cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_first_q  <= 8'hAA;
      sync_second_q <= 8'h55;
      id_limit_q    <= 8'd10;
    end else if (cfg_we) begin
      unique case (paddr[3:2])
        gsfd_pkg::RegSyncFirst:  sync_first_q  <= pwdata[7:0];
        gsfd_pkg::RegSyncSecond: sync_second_q <= pwdata[7:0];
        gsfd_pkg::RegIdLimit:    id_limit_q    <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      gsfd_pkg::RegSyncFirst:  prdata = {24'd0, sync_first_q};
      gsfd_pkg::RegSyncSecond: prdata = {24'd0, sync_second_q};
      gsfd_pkg::RegIdLimit:    prdata = {24'd0, id_limit_q};
      default:                 prdata = 32'd0;
    endcase
  end

  // collect side
  logic [1:0]  phase_q, phase_d;
  logic [4:0]  pos_q, pos_d;
  logic [7:0]  sum_q, sum_d;
  logic        col_bank_q, col_bank_d;
  logic [7:0]  id_q, sts_q, hi_q;
  logic [47:0] slow_q;
  logic        in_acc, at_sum;
  logic        ram_we;
  logic [gsfd_pkg::RamAw-1:0] ram_waddr;
  logic [gsfd_pkg::ChanW-1:0] wr_chan;
  logic [4:0]  wave_off;

  // emit side
  logic        em_busy_q, em_busy_d;
  logic        em_bank_q;
  logic [gsfd_pkg::ChanW-1:0] em_idx_q, em_idx_d;
  gsfd_pkg::err_e em_err_q, em_err_d;
  logic [7:0]  em_id_q, em_sts_q;
  logic [47:0] em_slow_q;
  logic [4:0]  em_inval_q, inval_d;
  logic        issue, em_last;
  logic        rd_pend_q;
  logic [gsfd_pkg::ChanW-1:0] pend_idx_q;
  logic [gsfd_pkg::RamAw-1:0] ram_raddr;
  logic [15:0] ram_rdata;
  logic [7:0]  want;
  logic        out_valid_q;

  assign at_sum     = (phase_q == PhCollect) && (pos_q == gsfd_pkg::PosSum);
  assign in_stall_o = at_sum && em_busy_q;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign want       = 8'(8'd0 - sum_q);

  assign wave_off  = pos_q - gsfd_pkg::PosWave;
  assign wr_chan   = wave_off[3:1];
  assign ram_we    = in_acc && (phase_q == PhCollect) && (pos_q >= gsfd_pkg::PosWave) &&
                     (pos_q < gsfd_pkg::PosSlow) && wave_off[0];
  assign ram_waddr = (col_bank_q ? BankOff : '0) + gsfd_pkg::RamAw'(wr_chan);

  always_comb begin
    inval_d = '0;
    if (id_q <= 8'd2) begin
      for (int i = 0; i < 5; i++) begin
        inval_d[i] = (slow_q[47-8*i -: 8] == 8'hFF);
      end
    end else if (id_q == 8'd3) begin
      inval_d[0] = (slow_q[15:0] == 16'hFFFF);
    end
  end

  always_comb begin
    phase_d    = phase_q;
    pos_d      = pos_q;
    sum_d      = sum_q;
    col_bank_d = col_bank_q;
    em_err_d   = gsfd_pkg::ErrOk;
    if (in_acc) begin
      unique case (phase_q)
        PhSync2: begin
          if (rx_byte_i == sync_second_q) begin
            phase_d = PhCollect;
            pos_d   = gsfd_pkg::PosId;
            sum_d   = '0;
          end else if (rx_byte_i != sync_first_q) begin
            phase_d = PhHunt;
          end
        end
        PhCollect: begin
          if (pos_q == gsfd_pkg::PosSum) begin
            phase_d    = PhHunt;
            pos_d      = '0;
            sum_d      = '0;
            col_bank_d = !col_bank_q;
          end else begin
            sum_d = 8'(sum_q + rx_byte_i);
            pos_d = 5'(pos_q + 5'd1);
          end
        end
        default: begin
          phase_d = (rx_byte_i == sync_first_q) ? PhSync2 : PhHunt;
        end
      endcase
    end
    if (want != rx_byte_i) begin
      em_err_d = gsfd_pkg::ErrSum;
    end else if (id_q >= id_limit_q) begin
      em_err_d = gsfd_pkg::ErrId;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PhHunt;
      pos_q      <= '0;
      sum_q      <= '0;
      col_bank_q <= 1'b0;
    end else begin
      phase_q    <= phase_d;
      pos_q      <= pos_d;
      sum_q      <= sum_d;
      col_bank_q <= col_bank_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && phase_q == PhCollect) begin
      if (pos_q == gsfd_pkg::PosId) id_q <= rx_byte_i;
      if (pos_q == gsfd_pkg::PosStatus) sts_q <= rx_byte_i;
      if (!wave_off[0]) hi_q <= rx_byte_i;
      if (pos_q >= gsfd_pkg::PosSlow) slow_q <= {slow_q[39:0], rx_byte_i};
    end
  end

  gsfd_ram #(
    .Width (16),
    .Depth (gsfd_pkg::RamDepth)
  ) u_wave_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i ({hi_q, rx_byte_i}),
    .re_i    (issue),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // emitter: one RAM read per item, output register after it
  assign issue     = em_busy_q && !rd_pend_q && (!out_valid_q || !out_stall_i);
  assign em_last   = (em_err_q != gsfd_pkg::ErrOk) || (em_idx_q == LastChan);
  assign ram_raddr = (em_bank_q ? BankOff : '0) + gsfd_pkg::RamAw'(em_idx_q);

  always_comb begin
    em_busy_d = em_busy_q;
    em_idx_d  = em_idx_q;
    if (issue) begin
      em_idx_d = 3'(em_idx_q + 3'd1);
      if (em_last) em_busy_d = 1'b0;
    end
    if (in_acc && at_sum) begin
      em_busy_d = 1'b1;
      em_idx_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      em_busy_q   <= 1'b0;
      em_idx_q    <= '0;
      rd_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      em_busy_q <= em_busy_d;
      em_idx_q  <= em_idx_d;
      rd_pend_q <= issue;
      if (rd_pend_q) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && at_sum) begin
      em_bank_q  <= col_bank_q;
      em_err_q   <= em_err_d;
      em_id_q    <= id_q;
      em_sts_q   <= sts_q;
      em_slow_q  <= slow_q;
      em_inval_q <= inval_d;
    end
    if (issue) pend_idx_q <= em_idx_q;
  end

  always_ff @(posedge clk_i) begin
    if (rd_pend_q) begin
      fault_code_o   <= em_err_q;
      frame_kind_o   <= em_id_q;
      status_flags_o <= em_sts_q;
      if (em_err_q != gsfd_pkg::ErrOk) begin
        channel_o      <= '0;
        wave_value_o   <= '0;
        wave_valid_o   <= 1'b0;
        slow_raw_o     <= '0;
        slow_invalid_o <= '0;
        last_o         <= 1'b1;
      end else begin
        channel_o      <= pend_idx_q;
        wave_value_o   <= ram_rdata;
        wave_valid_o   <= (ram_rdata != 16'hFFFF);
        slow_raw_o     <= em_slow_q;
        slow_invalid_o <= em_inval_q;
        last_o         <= (pend_idx_q == LastChan);
      end
    end
  end

  assign out_valid_o = out_valid_q;

`ifndef SYNTHESIS
  a_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_pend_q |-> !out_valid_q)
    else $error("read data lands on an occupied output register");

  a_bank_apart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_we && em_busy_q) |-> (em_bank_q != col_bank_q))
    else $error("collect and emit share a RAM bank");

  a_err_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && fault_code_o != gsfd_pkg::ErrOk) |-> (last_o && wave_value_o == 16'd0))
    else $error("error item is not a single zeroed item");
`endif

endmodule
`default_nettype wire
